// ----- rtl/wsg_pkg.sv -----
// wsg_pkg: shared types and constants for the multi-shape wave generator
// no dependencies
package wsg_pkg;

    localparam int DIV_STEPS = 15;
    localparam int DEN_W     = 17;
    localparam int REM_W     = 33;
    localparam int NUM_W     = 35;

    localparam logic [2:0] SHAPE_TRIANGLE  = 3'd0;
    localparam logic [2:0] SHAPE_SAWTOOTH  = 3'd1;
    localparam logic [2:0] SHAPE_INV_SAW   = 3'd2;
    localparam logic [2:0] SHAPE_PULSE     = 3'd3;
    localparam logic [2:0] SHAPE_SQUARE    = 3'd4;
    localparam logic [2:0] SHAPE_RECT      = 3'd5;
    localparam logic [2:0] SHAPE_RHOMBOID  = 3'd6;

    localparam logic       CFG_WAVE_SHAPE  = 1'b0;
    localparam logic       CFG_SHAPE_K     = 1'b1;

    localparam logic signed [15:0] Q14_ONE     = 16'sd16384;
    localparam logic signed [15:0] Q14_MIN_ONE = -16'sd16384;
    localparam logic        [16:0] K_ONE       = 17'd65536;

    typedef struct packed {
        logic                    direct;
        logic signed [15:0]      dval;
        logic                    neg;
        logic [REM_W-1:0]        rem;
        logic [DEN_W-1:0]        den;
        logic [DIV_STEPS-1:0]    quo;
    } div_t;

endpackage

// ----- rtl/wsg_front.sv -----
// wsg_front: phase capture, region select and divider set-up (three stages)
// depends on wsg_pkg
module wsg_front #(
    parameter int PHASE_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [PHASE_BITS-1:0] phase,
    input  logic [2:0]            wave_shape,
    input  logic [16:0]           shape_k,
    output logic                  out_valid,
    output wsg_pkg::div_t         out_data
);
    import wsg_pkg::*;

    localparam int XSH = 32 - PHASE_BITS;
    localparam logic signed [NUM_W-1:0] ONE_F = NUM_W'(64'h1_0000_0000);

    logic                    v1_reg, v2_reg, v3_reg;
    logic [31:0]             x_reg;
    logic [16:0]             k_reg;
    logic [2:0]              shape_reg;
    logic                    direct2_reg, direct2_next;
    logic signed [15:0]      dval2_reg, dval2_next;
    logic signed [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0]        den2_reg, den2_next;
    div_t                    d3_reg, d3_next;

    logic signed [NUM_W-1:0] x2, xs, kf;
    logic [16:0]             kinv;
    logic [NUM_W-2:0]        mag;
    logic [49:0]             nsum;
    logic [REM_W-1:0]        nred;
    logic [REM_W-1:0]        dlim;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= 32'(phase) << XSH;
        k_reg       <= (shape_k > K_ONE) ? K_ONE : shape_k;
        shape_reg   <= wave_shape;
        direct2_reg <= direct2_next;
        dval2_reg   <= dval2_next;
        num_reg     <= num_next;
        den2_reg    <= den2_next;
        d3_reg      <= d3_next;
    end

    // region select
    always_comb
    begin
        xs   = NUM_W'({1'b0, x_reg});
        x2   = NUM_W'({1'b0, x_reg, 1'b0});
        kf   = NUM_W'({k_reg, 16'b0});
        kinv = K_ONE - k_reg;
        direct2_next = 1'b0;
        dval2_next   = '0;
        num_next     = '0;
        den2_next    = K_ONE;
        unique case (shape_reg)
            SHAPE_TRIANGLE:
            begin
                if (x2 < ONE_F - kf)
                begin
                    num_next  = x2;
                    den2_next = kinv;
                end
                else if (x2 < ONE_F + kf)
                begin
                    num_next  = ONE_F - x2;
                    den2_next = k_reg;
                end
                else
                begin
                    num_next  = x2 - (ONE_F <<< 1);
                    den2_next = kinv;
                end
            end
            SHAPE_SAWTOOTH:
                num_next = ONE_F - x2;
            SHAPE_INV_SAW:
                num_next = x2 - ONE_F;
            SHAPE_PULSE:
            begin
                direct2_next = 1'b1;
                dval2_next   = (xs < kf) ? Q14_ONE : 16'sd0;
            end
            SHAPE_SQUARE:
            begin
                direct2_next = 1'b1;
                dval2_next   = (xs < kf) ? Q14_ONE : Q14_MIN_ONE;
            end
            SHAPE_RECT:
            begin
                if (xs < kf)
                begin
                    direct2_next = 1'b1;
                    dval2_next   = Q14_ONE;
                end
                else
                begin
                    num_next  = -kf;
                    den2_next = kinv;
                end
            end
            SHAPE_RHOMBOID:
            begin
                den2_next = k_reg;
                if (x2 < kf)
                    num_next = x2;
                else if (x2 < ONE_F - kf)
                begin
                    direct2_next = 1'b1;
                    dval2_next   = Q14_ONE;
                end
                else if (x2 < ONE_F + kf)
                    num_next = ONE_F - x2;
                else if (x2 < (ONE_F <<< 1) - kf)
                begin
                    direct2_next = 1'b1;
                    dval2_next   = Q14_MIN_ONE;
                end
                else
                    num_next = x2 - (ONE_F <<< 1);
            end
            default:
            begin
                direct2_next = 1'b1;
                dval2_next   = '0;
            end
        endcase
    end

    // rounding offset and range check ahead of the divider
    always_comb
    begin
        mag  = num_reg[NUM_W-1] ? (NUM_W-1)'(-num_reg) : num_reg[NUM_W-2:0];
        nsum = (50'(mag) << 14) + (50'(den2_reg) << 15);
        nred = REM_W'(nsum >> 16);
        dlim = REM_W'(den2_reg) << DIV_STEPS;
        d3_next.direct = direct2_reg;
        d3_next.dval   = dval2_reg;
        d3_next.neg    = num_reg[NUM_W-1];
        d3_next.rem    = nred;
        d3_next.den    = den2_reg;
        d3_next.quo    = '0;
        if (!direct2_reg)
        begin
            if (den2_reg == '0)
            begin
                d3_next.direct = 1'b1;
                if (num_reg > 0)
                    d3_next.dval = Q14_ONE;
                else if (num_reg < 0)
                    d3_next.dval = Q14_MIN_ONE;
                else
                    d3_next.dval = '0;
            end
            else if (nred >= dlim)
            begin
                d3_next.direct = 1'b1;
                d3_next.dval   = num_reg[NUM_W-1] ? Q14_MIN_ONE : Q14_ONE;
            end
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = d3_reg;

endmodule

// ----- rtl/wsg_div_step.sv -----
// wsg_div_step: one restoring division step, one quotient bit per stage
// depends on wsg_pkg
module wsg_div_step #(
    parameter int BIT = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  wsg_pkg::div_t in_data,
    output logic          out_valid,
    output wsg_pkg::div_t out_data
);
    import wsg_pkg::*;

    logic             valid_reg;
    div_t             data_reg, data_next;
    logic [REM_W-1:0] dsh;

    always_comb
    begin
        dsh       = REM_W'(in_data.den) << BIT;
        data_next = in_data;
        if (in_data.rem >= dsh)
        begin
            data_next.rem      = in_data.rem - dsh;
            data_next.quo[BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- rtl/multi_shape_wave_generator.sv -----
// multi_shape_wave_generator: top level, configuration registers, divider chain, output
// pipeline from start to result_valid: 3 set-up stages, 15 divider stages,
// 1 output stage; one phase word taken every cycle, busy stays low
// reset clears the pipeline valid bits and loads wave_shape 0 and shape_k 32768
// depends on wsg_pkg, wsg_front, wsg_div_step
module multi_shape_wave_generator #(
    parameter int PHASE_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [PHASE_BITS-1:0] phase,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [16:0]           cfg_data,
    output logic                  result_valid,
    output logic signed [15:0]    wave_value
);
    import wsg_pkg::*;

    logic [2:0]  wave_shape_reg;
    logic [16:0] shape_k_reg;
    logic              vout_reg;
    logic signed [15:0] wave_reg, wave_next;
    logic [DIV_STEPS-1:0] qc;

    logic vs [DIV_STEPS+1];
    div_t ds [DIV_STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_shape_reg <= SHAPE_TRIANGLE;
            shape_k_reg    <= 17'd32768;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_WAVE_SHAPE: wave_shape_reg <= cfg_data[2:0];
                CFG_SHAPE_K:    shape_k_reg    <= cfg_data;
                default:        ;
            endcase
        end
    end

    wsg_front #(
        .PHASE_BITS(PHASE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .phase     (phase),
        .wave_shape(wave_shape_reg),
        .shape_k   (shape_k_reg),
        .out_valid (vs[0]),
        .out_data  (ds[0])
    );

    // quotient bits from the top down
    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        wsg_div_step #(
            .BIT(DIV_STEPS - 1 - i)
        ) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (vs[i]),
            .in_data  (ds[i]),
            .out_valid(vs[i+1]),
            .out_data (ds[i+1])
        );
    end

    always_comb
    begin
        qc = (ds[DIV_STEPS].quo > DIV_STEPS'(16384)) ? DIV_STEPS'(16384)
                                                    : ds[DIV_STEPS].quo;
        if (ds[DIV_STEPS].direct)
            wave_next = ds[DIV_STEPS].dval;
        else if (ds[DIV_STEPS].neg)
            wave_next = -$signed({1'b0, qc});
        else
            wave_next = $signed({1'b0, qc});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vout_reg <= 1'b0;
        else
            vout_reg <= vs[DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        wave_reg <= wave_next;
    end

    assign busy         = 1'b0;
    assign cfg_ready    = 1'b1;
    assign result_valid = vout_reg;
    assign wave_value   = wave_reg;

endmodule
